@@ rtl/dttu_pkg.sv @@
// Shared types, character codes and the power-of-ten table for the decimal text converter.
`timescale 1ns / 1ps

package dttu_pkg;

	// Default limit on kept fraction digits
	localparam int MAX_FRACTION_DIGITS_DEF = 9;

	// Character codes
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_POINT = 8'h2E;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_NUL   = 8'h00;

	// Result constants
	localparam logic [7:0] U8_MAX  = 8'hFF;
	localparam logic [3:0] INT_MAX = 4'd15;

	// Fraction conversion: one result bit per step
	localparam int DIV_STEPS = 4;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	// Parse phase of the number
	typedef enum logic [1:0] {
		PH_INT,
		PH_FRAC,
		PH_END
	} phase_t;

	// Controller states
	typedef enum logic [1:0] {
		S_PARSE,
		S_DIV,
		S_LOAD
	} ctrl_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic parse;
		logic div_step;
		logic load_out;
		logic clear;
	} dp_cmd_t;

	// Ten to the power n, for n up to nine
	function automatic logic [31:0] pow10_f(input logic [3:0] n);
		logic [31:0] r;
		unique case (n)
			4'd0: r = 32'd1;
			4'd1: r = 32'd10;
			4'd2: r = 32'd100;
			4'd3: r = 32'd1000;
			4'd4: r = 32'd10000;
			4'd5: r = 32'd100000;
			4'd6: r = 32'd1000000;
			4'd7: r = 32'd10000000;
			4'd8: r = 32'd100000000;
			4'd9: r = 32'd1000000000;
			default: r = 32'd1000000000;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/dttu_dp.sv @@
// Datapath: character parser, accumulators, fraction-to-nibble divider and result register.
`timescale 1ns / 1ps

module dttu_dp #(
	parameter int MAX_FRACTION_DIGITS = dttu_pkg::MAX_FRACTION_DIGITS_DEF,
	parameter int FRAC_W = 30,
	parameter int DIG_W  = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dttu_pkg::dp_cmd_t cmd,
	input  logic [7:0]       char_code,
	output logic [7:0]       fixed_value,
	output logic             saturated,
	output logic             bad_char
);
	import dttu_pkg::*;

	phase_t            phase_q;
	logic [3:0]        int_q;
	logic              too_big_q;
	logic [FRAC_W-1:0] frac_q;
	logic [DIG_W-1:0]  digits_q;
	logic              err_q;
	logic [3:0]        bits_q;

	logic              is_digit;
	logic              is_term;
	logic              is_point;
	logic [3:0]        digit;
	logic [7:0]        int_next;
	logic [FRAC_W+3:0] frac_ext;
	logic [FRAC_W+3:0] frac_next;
	logic              room;
	logic [31:0]       pow_full;
	logic [FRAC_W-1:0] one_v;
	logic [FRAC_W:0]   dbl;
	logic [FRAC_W:0]   diff;
	logic              ge;

	// Character classes
	always_comb begin
		is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
		is_term  = (char_code == CHAR_LF) || (char_code == CHAR_NUL);
		is_point = (char_code == CHAR_POINT);
		digit    = is_digit ? 4'(char_code - CHAR_ZERO) : 4'd0;
	end

	// Decimal multiply-add for both parts: acc * 10 + digit as two shifts and adds
	always_comb begin
		int_next  = ({4'b0, int_q} << 3) + ({4'b0, int_q} << 1) + {4'b0, digit};
		frac_ext  = {4'b0, frac_q};
		frac_next = (frac_ext << 3) + (frac_ext << 1) + {{FRAC_W{1'b0}}, digit};
		room      = digits_q < DIG_W'(MAX_FRACTION_DIGITS);
	end

	// One restoring step of fraction / 10^digits
	always_comb begin
		pow_full = pow10_f(4'(digits_q));
		one_v    = pow_full[FRAC_W-1:0];
		dbl      = {frac_q, 1'b0};
		ge       = dbl >= {1'b0, one_v};
		diff     = dbl - {1'b0, one_v};
	end

	// Parse state and divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_INT;
			int_q     <= '0;
			too_big_q <= 1'b0;
			frac_q    <= '0;
			digits_q  <= '0;
			err_q     <= 1'b0;
		end else begin
			priority if (cmd.clear) begin
				phase_q   <= PH_INT;
				int_q     <= '0;
				too_big_q <= 1'b0;
				frac_q    <= '0;
				digits_q  <= '0;
				err_q     <= 1'b0;
			end else if (cmd.div_step) begin
				frac_q <= ge ? diff[FRAC_W-1:0] : dbl[FRAC_W-1:0];
			end else if (cmd.parse) begin
				unique case (phase_q)
					PH_INT: begin
						priority if (is_term) begin
							phase_q <= PH_END;
						end else if (is_point) begin
							phase_q <= PH_FRAC;
						end else if (is_digit) begin
							if (int_next > {4'b0, INT_MAX}) begin
								too_big_q <= 1'b1;
								int_q     <= INT_MAX;
							end else begin
								int_q <= int_next[3:0];
							end
						end else begin
							err_q <= 1'b1;
						end
					end
					PH_FRAC: begin
						priority if (is_term) begin
							phase_q <= PH_END;
						end else if (is_digit) begin
							if (room) begin
								frac_q   <= frac_next[FRAC_W-1:0];
								digits_q <= digits_q + DIG_W'(1);
							end
						end else begin
							err_q <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Quotient bits shift in MSB first
	always_ff @(posedge clk) begin
		if (cmd.div_step) begin
			bits_q <= {bits_q[2:0], ge};
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			fixed_value <= (too_big_q || err_q) ? U8_MAX : {int_q, bits_q};
			saturated   <= too_big_q;
			bad_char    <= err_q;
		end
	end

endmodule

@@ rtl/dttu_ctrl.sv @@
// Controller: sequences parsing, the four divider steps and the result transfer.
`timescale 1ns / 1ps

module dttu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              is_last,
	output logic              out_valid,
	input  logic              out_stall,
	output dttu_pkg::dp_cmd_t cmd
);
	import dttu_pkg::*;

	ctrl_state_t      state_q;
	ctrl_state_t      state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             in_xfer;
	logic             out_free;

	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_PARSE: if (in_xfer && is_last) state_d = S_DIV;
			S_DIV:   if (cnt_q == CNT_LAST) state_d = S_LOAD;
			S_LOAD:  if (out_free) state_d = S_PARSE;
			default: state_d = S_PARSE;
		endcase
	end

	// Outputs and datapath commands
	always_comb begin
		in_stall     = 1'b1;
		cmd          = '0;
		unique case (state_q)
			S_PARSE: begin
				in_stall  = 1'b0;
				cmd.parse = in_valid;
			end
			S_DIV: cmd.div_step = 1'b1;
			S_LOAD: begin
				cmd.load_out = out_free;
				cmd.clear    = out_free;
			end
			default: begin
			end
		endcase
	end

	// State, step count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_PARSE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_q == S_DIV) ? cnt_q + CNT_W'(1) : '0;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// A last character starts the divider
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PARSE && in_xfer && is_last |=> state_q == S_DIV)
		else $error("last transfer did not start division");

	// Exactly four divider steps, then load
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && cnt_q == CNT_LAST |=> state_q == S_LOAD)
		else $error("divider did not end after four steps");

	// The step counter is idle outside division
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_DIV |-> cnt_q == '0)
		else $error("step counter running outside division");

	// A load never overwrites a result that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid_q && out_stall))
		else $error("result register overwritten");

	// A loaded result is offered next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not valid");
`endif

endmodule

@@ rtl/decimal_text_to_uq44.sv @@
// Top level of the decimal text to unsigned 4.4 fixed-point converter.
`timescale 1ns / 1ps

// Takes a decimal number as ASCII characters, one per transfer, and gives its unsigned
// 4.4 value after the transfer with is_last set. The character marked last is parsed
// and then followed by the steps of the restoring divider that turns the fraction into
// sixteenths and by the load of the result register; the input is stalled during the
// divider steps and until the single result register is free. A finished result may
// wait in its register while the next number's characters are taken. An integer part
// of 16 or more gives 255 with saturated set; a character other than a digit, one
// point, newline or NUL gives 255 with bad_char set. Newline or NUL ends the number
// and the characters after it are ignored; fraction digits beyond MAX_FRACTION_DIGITS
// are also ignored.
module decimal_text_to_uq44 #(
	parameter int MAX_FRACTION_DIGITS = dttu_pkg::MAX_FRACTION_DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] fixed_value,
	output logic       saturated,
	output logic       bad_char
);
	import dttu_pkg::*;

	localparam int FRAC_W = $clog2(pow10_f(4'(MAX_FRACTION_DIGITS)));
	localparam int DIG_W  = $clog2(MAX_FRACTION_DIGITS + 1);

	dp_cmd_t cmd;

	// Sequencer
	dttu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.is_last   (is_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Parser, divider and result register
	dttu_dp #(
		.MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS),
		.FRAC_W              (FRAC_W),
		.DIG_W               (DIG_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.char_code   (char_code),
		.fixed_value (fixed_value),
		.saturated   (saturated),
		.bad_char    (bad_char)
	);

endmodule

@@ verif/decimal_text_to_uq44_tb.sv @@
// Self-checking testbench for the decimal text to unsigned 4.4 fixed-point converter.
`timescale 1ns / 1ps

module decimal_text_to_uq44_tb;
	import dttu_pkg::*;

	localparam int FRAC_KEEP    = (MAX_FRACTION_DIGITS_DEF < 9) ? MAX_FRACTION_DIGITS_DEF : 9;
	localparam int CHAR_TARGET  = 1800;
	localparam int QUIET_FROM   = 1500;
	localparam int STUCK_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 20;

	typedef logic [7:0] char_t;

	typedef struct packed {
		logic [7:0] value;
		logic       sat;
		logic       bad;
	} uq44_result_t;

	// Tracks the parse of the current number and holds the values still owed by the block
	class uq44_checker;
		phase_t       ph;
		logic [3:0]   int_part;
		bit           int_over;
		logic [29:0]  frac_part;
		logic [3:0]   frac_count;
		bit           char_err;
		uq44_result_t pending_values[$];
		int           fails;

		function new();
			fails = 0;
			restart();
		endfunction

		function void restart();
			ph = PH_INT;
			int_part = '0;
			int_over = 0;
			frac_part = '0;
			frac_count = '0;
			char_err = 0;
		endfunction

		function logic [63:0] ten_to(input logic [3:0] n);
			logic [63:0] r;
			r = 64'd1;
			for (int i = 0; i < n; i++)
				r = r * 10;
			return r;
		endfunction

		// Parse one accepted character; on the last one queue the expected value
		function void take_char(input char_t c, input logic last);
			bit           digit;
			bit           term;
			int           d;
			int           acc;
			logic [63:0]  rem;
			logic [63:0]  unit;
			logic [3:0]   sixteenths;
			uq44_result_t r;
			digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
			term = (c == CHAR_LF) || (c == CHAR_NUL);
			d = digit ? int'(c - CHAR_ZERO) : 0;
			case (ph)
				PH_INT: begin
					if (term)
						ph = PH_END;
					else if (c == CHAR_POINT)
						ph = PH_FRAC;
					else if (digit) begin
						acc = int'(int_part) * 10 + d;
						if (acc > int'(INT_MAX)) begin
							int_over = 1;
							int_part = INT_MAX;
						end else
							int_part = acc[3:0];
					end else
						char_err = 1;
				end
				PH_FRAC: begin
					if (term)
						ph = PH_END;
					else if (digit) begin
						// digits past the limit are dropped
						if (frac_count < FRAC_KEEP) begin
							frac_part = frac_part * 10 + d;
							frac_count++;
						end
					end else
						char_err = 1;
				end
				default: ;
			endcase
			if (!last)
				return;
			// restoring division of the fraction into sixteenths, truncated
			rem = 64'(frac_part);
			unit = ten_to(frac_count);
			sixteenths = '0;
			repeat (4) begin
				rem = rem << 1;
				sixteenths = sixteenths << 1;
				if (rem >= unit) begin
					sixteenths[0] = 1'b1;
					rem = rem - unit;
				end
			end
			r.value = (int_over || char_err) ? U8_MAX : {int_part, sixteenths};
			r.sat = int_over;
			r.bad = char_err;
			pending_values.push_back(r);
			restart();
		endfunction

		// Compare one accepted result with the oldest expected value
		function void match_value(input logic [7:0] v, input logic s, input logic b);
			uq44_result_t e;
			if (pending_values.size() == 0) begin
				$display("%0t: unexpected result fixed_value %0d saturated %0d bad_char %0d",
					$time, v, s, b);
				fails++;
				return;
			end
			e = pending_values.pop_front();
			if (v !== e.value) begin
				$display("%0t: fixed_value expected %0d actual %0d", $time, e.value, v);
				fails++;
			end
			if (s !== e.sat) begin
				$display("%0t: saturated expected %0d actual %0d", $time, e.sat, s);
				fails++;
			end
			if (b !== e.bad) begin
				$display("%0t: bad_char expected %0d actual %0d", $time, e.bad, b);
				fails++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] char_code;
	logic       is_last;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] fixed_value;
	logic       saturated;
	logic       bad_char;

	uq44_checker chk;
	char_t       text_q[$];
	bit          idle_on;
	bit          quiet;
	int          sent_chars;
	int          stuck_cycles;
	int          stall_left;

	decimal_text_to_uq44 dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_code   (char_code),
		.is_last     (is_last),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.fixed_value (fixed_value),
		.saturated   (saturated),
		.bad_char    (bad_char)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Send one character, with an occasional idle burst before it
	task automatic send_char(input char_t c, input logic last);
		int gap;
		if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		is_last <= last;
		do @(posedge clk); while (in_stall);
		chk.take_char(c, last);
		sent_chars++;
		if (sent_chars >= QUIET_FROM)
			quiet = 1;
	endtask

	// Send the buffered text as one number, last flag on its final character
	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_char(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(char_t'(s[i]));
		send_text();
	endtask

	task automatic push_digits(input int n);
		repeat (n) text_q.push_back(char_t'(CHAR_ZERO + $urandom_range(0, 9)));
	endtask

	// Build one random number: mostly well formed, some broken, some raw noise
	task automatic build_number();
		int kind;
		int n;
		int pos;
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			n = $urandom_range(1, 6);
			repeat (n) text_q.push_back(char_t'($urandom_range(0, 255)));
		end else begin
			push_digits($urandom_range(0, 3));
			if ($urandom_range(0, 3) != 0) begin
				text_q.push_back(CHAR_POINT);
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
				push_digits(n);
			end
			// early terminator, then trailing characters that must be ignored
			if ($urandom_range(0, 4) == 0) begin
				text_q.push_back($urandom_range(0, 1) ? CHAR_LF : CHAR_NUL);
				n = $urandom_range(0, 3);
				repeat (n) text_q.push_back(char_t'($urandom_range(0, 255)));
			end
			if (kind >= 80) begin
				pos = $urandom_range(0, text_q.size());
				text_q.insert(pos, ($urandom_range(0, 2) == 0) ? CHAR_POINT :
					char_t'($urandom_range(0, 255)));
			end
			if (text_q.size() == 0)
				push_digits(1);
		end
	endtask

	// Result side: check transfers and drive random stall bursts
	initial begin
		out_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				chk.match_value(fixed_value, saturated, bad_char);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (idle_on && !quiet && !out_stall && $urandom_range(0, 9) == 0) begin
				// a new burst only starts once out_stall has dropped
				stall_left = $urandom_range(1, 14) - 1;
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	// Watchdog: no transfer on either side for too long
	initial stuck_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else
			stuck_cycles <= stuck_cycles + 1;
	end

	// Main sequence
	initial begin
		chk = new();
		in_valid = 1'b0;
		char_code = '0;
		is_last = 1'b0;
		arst_n = 1'b0;
		idle_on = 1;
		quiet = 0;
		sent_chars = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// largest integer part without saturation, plain saturation
		send_str("15.9");
		send_str("16");
		// terminator alone as the last character
		text_q = {CHAR_NUL};
		send_text();
		// newline ends the number, trailing junk ignored
		send_str("1\nx");
		// second point is a bad character
		send_str(".1.");
		// tenth fraction digit is dropped
		send_str(".9999999999");
		// saturation and bad character together, top character code
		text_q = {CHAR_NINE, CHAR_NINE, 8'hFF};
		send_text();

		while (sent_chars < CHAR_TARGET) begin
			build_number();
			send_text();
			if ($urandom_range(0, 9) == 0)
				idle_on = !idle_on;
		end
		in_valid <= 1'b0;

		while (chk.pending_values.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (chk.fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
